>>> hw/rtl/qsh_pkg.sv
// shared constants, datapath command codes and status type for the quicksort sorter
package qsh_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int CMD_W  = 4;

   localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INIT      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_CHECK     = 4'd3;
   localparam logic [CMD_W-1:0] CMD_POP       = 4'd4;
   localparam logic [CMD_W-1:0] CMD_PIVOT     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SCAN_I    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SCAN_J    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SWAP      = 4'd8;
   localparam logic [CMD_W-1:0] CMD_READ_I    = 4'd9;
   localparam logic [CMD_W-1:0] CMD_SPLIT     = 4'd10;
   localparam logic [CMD_W-1:0] CMD_OUT_FIRST = 4'd11;
   localparam logic [CMD_W-1:0] CMD_EMIT      = 4'd12;

   typedef struct packed {
      logic lo_lt_hi;
      logic sp_zero;
      logic i_advance;
      logic j_retreat;
      logic i_ge_j;
      logic k_last;
   } dp_status_type;

endpackage

>>> hw/rtl/quicksort_hoare_sorter_top.sv
// top level of the quicksort sorter: sequencer plus datapath
//
// Values are loaded one request per cycle while busy is low; a request with
// req_is_last set starts the sort and busy stays high until the run has been
// returned. Up to DEPTH values are kept, further ones are discarded and
// rsp_dropped is set on every result of that run. The sort is an in-place
// Hoare quicksort with a middle pivot over a single-read, single-write store,
// so each scan step reads one element, a swap writes one side as the j scan
// stops and the other in the SWAP state, and each sub-range passes through
// CHECK and PIVOT, with a POP when it comes off the range stack.
// Results then follow on consecutive cycles, one per rsp_strobe, after one
// cycle of setup, and must be taken as they come: the receiver cannot stall.
module quicksort_hoare_sorter_top
   import qsh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_last,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_is_final,
   output logic                     rsp_dropped
);

   logic [CMD_W-1:0] cmd;
   dp_status_type    status;

   qsh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_last (req_is_last),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   qsh_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .status           (status),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_is_final     (rsp_is_final),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

>>> hw/rtl/qsh_ctrl.sv
// sequencer for load, partition, range stack and emit phases
module qsh_ctrl
   import qsh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_is_last,
   input  dp_status_type      status,
   output logic [CMD_W-1:0]   cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INIT      = 4'd1;
   localparam logic [3:0] ST_CHECK     = 4'd2;
   localparam logic [3:0] ST_POP       = 4'd3;
   localparam logic [3:0] ST_PIVOT     = 4'd4;
   localparam logic [3:0] ST_SCAN_I    = 4'd5;
   localparam logic [3:0] ST_SCAN_J    = 4'd6;
   localparam logic [3:0] ST_SWAP      = 4'd7;
   localparam logic [3:0] ST_READ_I    = 4'd8;
   localparam logic [3:0] ST_SPLIT     = 4'd9;
   localparam logic [3:0] ST_OUT_FIRST = 4'd10;
   localparam logic [3:0] ST_EMIT      = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd = CMD_LOAD;
               if (req_is_last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd      = CMD_INIT;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd = CMD_CHECK;
            if (status.lo_lt_hi) begin
               state_in = ST_PIVOT;
            end else if (status.sp_zero) begin
               state_in = ST_OUT_FIRST;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd      = CMD_POP;
            state_in = ST_CHECK;
         end
         ST_PIVOT: begin
            cmd      = CMD_PIVOT;
            state_in = ST_SCAN_I;
         end
         ST_SCAN_I: begin
            cmd = CMD_SCAN_I;
            if (!status.i_advance) begin
               state_in = ST_SCAN_J;
            end
         end
         ST_SCAN_J: begin
            cmd = CMD_SCAN_J;
            if (!status.j_retreat) begin
               state_in = status.i_ge_j ? ST_SPLIT : ST_SWAP;
            end
         end
         ST_SWAP: begin
            cmd      = CMD_SWAP;
            state_in = ST_READ_I;
         end
         ST_READ_I: begin
            cmd      = CMD_READ_I;
            state_in = ST_SCAN_I;
         end
         ST_SPLIT: begin
            cmd      = CMD_SPLIT;
            state_in = ST_CHECK;
         end
         ST_OUT_FIRST: begin
            cmd      = CMD_OUT_FIRST;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd = CMD_EMIT;
            if (status.k_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_EMIT);

endmodule

>>> hw/rtl/qsh_dp.sv
// element store, range stack, scan indices and compare logic
module qsh_dp
   import qsh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CMD_W-1:0]         cmd,
   input  logic signed [DATA_W-1:0] req_value,
   output dp_status_type            status,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_is_final,
   output logic                     rsp_dropped
);

   logic signed [DATA_W-1:0] store_mem [DEPTH];
   logic [2*IDX_W-1:0]       stack_mem [DEPTH];

   logic signed [DATA_W-1:0] rd_data_ff;
   logic [2*IDX_W-1:0]       stk_data_ff;

   logic [CNT_W-1:0]         count_ff;
   logic                     over_ff;
   logic [CNT_W-1:0]         sp_ff;
   logic [IDX_W-1:0]         lo_ff;
   logic [IDX_W-1:0]         hi_ff;
   logic [IDX_W-1:0]         i_ff;
   logic [IDX_W-1:0]         j_ff;
   logic [IDX_W-1:0]         mid_ff;
   logic [IDX_W-1:0]         k_ff;
   logic signed [DATA_W-1:0] pivot_ff;
   logic signed [DATA_W-1:0] ival_ff;

   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     push_en;
   logic [2*IDX_W-1:0]       push_data;

   logic [CNT_W-1:0]         count_dec;
   logic [CNT_W-1:0]         sp_dec;
   logic [IDX_W-1:0]         mid_calc;
   logic [IDX_W-1:0]         split_m;
   logic [IDX_W:0]           two_m_plus1;
   logic [IDX_W:0]           lo_plus_hi;
   logic                     left_smaller;
   logic                     count_full;
   logic                     sp_full;

   assign count_dec   = count_ff - 1'b1;
   assign sp_dec      = sp_ff - 1'b1;
   assign mid_calc    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign split_m     = ((j_ff < lo_ff) || (j_ff >= hi_ff)) ? mid_ff : j_ff;
   assign two_m_plus1 = {split_m, 1'b1};
   assign lo_plus_hi  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign left_smaller = (two_m_plus1 < lo_plus_hi);
   assign count_full  = (count_ff >= CNT_W'(DEPTH));
   assign sp_full     = (sp_ff >= CNT_W'(DEPTH));

   assign status.lo_lt_hi  = (lo_ff < hi_ff);
   assign status.sp_zero   = (sp_ff == '0);
   assign status.i_advance = (i_ff < hi_ff) && (rd_data_ff < pivot_ff);
   assign status.j_retreat = (j_ff > lo_ff) && (rd_data_ff > pivot_ff);
   assign status.i_ge_j    = (i_ff >= j_ff);
   assign status.k_last    = ({1'b0, k_ff} == count_dec);

   // store address and write selection
   always_comb begin
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = i_ff;
      wr_data   = rd_data_ff;
      push_en   = 1'b0;
      push_data = {lo_ff, split_m};
      case (cmd)
         CMD_LOAD: begin
            wr_en   = !count_full;
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = req_value;
         end
         CMD_CHECK: begin
            rd_addr = mid_calc;
         end
         CMD_PIVOT: begin
            rd_addr = lo_ff;
         end
         CMD_SCAN_I: begin
            rd_addr = status.i_advance ? (i_ff + 1'b1) : j_ff;
         end
         CMD_SCAN_J: begin
            rd_addr = j_ff - 1'b1;
            wr_en   = !status.j_retreat && !status.i_ge_j;
            wr_addr = i_ff;
            wr_data = rd_data_ff;
         end
         CMD_SWAP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = ival_ff;
         end
         CMD_READ_I: begin
            rd_addr = i_ff;
         end
         CMD_SPLIT: begin
            push_en   = !sp_full;
            push_data = left_smaller ? {split_m + 1'b1, hi_ff} : {lo_ff, split_m};
         end
         CMD_OUT_FIRST: begin
            rd_addr = '0;
         end
         CMD_EMIT: begin
            rd_addr = k_ff + 1'b1;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[sp_ff[IDX_W-1:0]] <= push_data;
      end
      stk_data_ff <= stack_mem[sp_dec[IDX_W-1:0]];
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         over_ff  <= 1'b0;
         sp_ff    <= '0;
      end else begin
         case (cmd)
            CMD_LOAD: begin
               if (count_full) begin
                  over_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            CMD_INIT: begin
               sp_ff <= '0;
            end
            CMD_CHECK: begin
               if (!status.lo_lt_hi && !status.sp_zero) begin
                  sp_ff <= sp_dec;
               end
            end
            CMD_SPLIT: begin
               if (!sp_full) begin
                  sp_ff <= sp_ff + 1'b1;
               end
            end
            CMD_EMIT: begin
               if (status.k_last) begin
                  count_ff <= '0;
                  over_ff  <= 1'b0;
                  sp_ff    <= '0;
               end
            end
            default: begin
               sp_ff <= sp_ff;
            end
         endcase
      end
   end

   // range and scan registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_INIT: begin
            lo_ff <= '0;
            hi_ff <= count_dec[IDX_W-1:0];
         end
         CMD_CHECK: begin
            mid_ff <= mid_calc;
         end
         CMD_POP: begin
            lo_ff <= stk_data_ff[2*IDX_W-1:IDX_W];
            hi_ff <= stk_data_ff[IDX_W-1:0];
         end
         CMD_PIVOT: begin
            pivot_ff <= rd_data_ff;
            i_ff     <= lo_ff;
            j_ff     <= hi_ff;
         end
         CMD_SCAN_I: begin
            if (status.i_advance) begin
               i_ff <= i_ff + 1'b1;
            end else begin
               ival_ff <= rd_data_ff;
            end
         end
         CMD_SCAN_J: begin
            if (status.j_retreat) begin
               j_ff <= j_ff - 1'b1;
            end
         end
         CMD_SWAP: begin
            i_ff <= i_ff + 1'b1;
            j_ff <= j_ff - 1'b1;
         end
         CMD_SPLIT: begin
            if (left_smaller) begin
               hi_ff <= split_m;
            end else begin
               lo_ff <= split_m + 1'b1;
            end
         end
         CMD_OUT_FIRST: begin
            k_ff <= '0;
         end
         CMD_EMIT: begin
            k_ff <= k_ff + 1'b1;
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   assign rsp_sorted_value = rd_data_ff;
   assign rsp_is_final     = status.k_last;
   assign rsp_dropped      = over_ff;

endmodule

>>> sim/quicksort_hoare_sorter_checker.sv
`timescale 1ns / 1ps
// watches both channels of the quicksort sorter, predicts each sorted run and compares results
module quicksort_hoare_sorter_checker
   import qsh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_last,
   input  logic                     rsp_strobe,
   input  logic signed [DATA_W-1:0] rsp_sorted_value,
   input  logic                     rsp_is_final,
   input  logic                     rsp_dropped,
   output int                       error_count,
   output int                       pending_count
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     is_final;
      logic                     dropped;
   } sorted_entry_type;

   logic signed [DATA_W-1:0] loaded_values [DEPTH];
   int                       loaded_total;
   logic                     overflow_seen;
   sorted_entry_type         expected_sorted [$];
   int                       result_index;

   initial begin
      error_count   = 0;
      pending_count = 0;
      loaded_total  = 0;
      overflow_seen = 1'b0;
      result_index  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   // ascending order of the loaded values, as any correct sort leaves them
   task automatic sort_loaded_values();
      logic signed [DATA_W-1:0] key;
      int                       b;
      for (int a = 1; a < loaded_total; a++) begin
         key = loaded_values[a];
         b   = a - 1;
         while (b >= 0 && loaded_values[b] > key) begin
            loaded_values[b + 1] = loaded_values[b];
            b--;
         end
         loaded_values[b + 1] = key;
      end
   endtask

   task automatic load_request(input logic signed [DATA_W-1:0] value, input logic last);
      sorted_entry_type entry;
      if (loaded_total < DEPTH) begin
         loaded_values[loaded_total] = value;
         loaded_total++;
      end else begin
         overflow_seen = 1'b1;
      end
      if (last) begin
         sort_loaded_values();
         for (int k = 0; k < loaded_total; k++) begin
            entry.value    = loaded_values[k];
            entry.is_final = (k == loaded_total - 1);
            entry.dropped  = overflow_seen;
            expected_sorted.push_back(entry);
         end
         loaded_total  = 0;
         overflow_seen = 1'b0;
      end
   endtask

   task automatic check_result();
      sorted_entry_type entry;
      if (expected_sorted.size() == 0) begin
         report_mismatch($sformatf("result %0d (value %0d) with no request pending",
                                   result_index, rsp_sorted_value));
      end else begin
         entry = expected_sorted.pop_front();
         if (rsp_sorted_value !== entry.value || rsp_is_final !== entry.is_final ||
             rsp_dropped !== entry.dropped) begin
            report_mismatch($sformatf(
               "result %0d: value %0d final %b dropped %b, expected %0d final %b dropped %b",
               result_index, rsp_sorted_value, rsp_is_final, rsp_dropped,
               entry.value, entry.is_final, entry.dropped));
         end
      end
      result_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loaded_total  = 0;
         overflow_seen = 1'b0;
         expected_sorted.delete();
      end else begin
         if (rsp_strobe) begin
            check_result();
         end
         if (start && !busy) begin
            load_request(req_value, req_is_last);
         end
      end
      pending_count = expected_sorted.size();
   end

endmodule

>>> sim/quicksort_hoare_sorter_top_test.sv
`timescale 1ns / 1ps
// testbench top for the quicksort sorter: clock, reset, request stimulus, watchdog and verdict
module quicksort_hoare_sorter_top_test;
   import qsh_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int RANDOM_ITEMS   = 135;
   localparam int QUIET_FROM     = 110;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum int {SET_RANDOM, SET_ASCENDING, SET_DESCENDING, SET_CONSTANT} set_shape_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_value;
   logic                     req_is_last;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_is_final;
   logic                     rsp_dropped;

   int error_count;
   int pending_count;
   int idle_cycles = 0;
   int items_sent  = 0;
   bit quiet       = 1'b0;

   always #10 clock = ~clock;

   quicksort_hoare_sorter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_is_final     (rsp_is_final),
      .rsp_dropped      (rsp_dropped)
   );

   quicksort_hoare_sorter_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_is_final     (rsp_is_final),
      .rsp_dropped      (rsp_dropped),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_value(input logic signed [DATA_W-1:0] value, input logic last);
      int gap;
      quiet = (items_sent >= QUIET_FROM);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_value   <= value;
      req_is_last <= last;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 3))
         1: return $urandom_range(0, 15) - 8;
         2: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(input int size, input set_shape_type shape);
      logic signed [DATA_W-1:0] fill;
      logic signed [DATA_W-1:0] value;
      fill = random_value();
      for (int k = 0; k < size; k++) begin
         case (shape)
            SET_ASCENDING:  value = k * 3 - 100;
            SET_DESCENDING: value = 100 - k * 3;
            SET_CONSTANT:   value = fill;
            default:        value = random_value();
         endcase
         send_value(value, k == size - 1);
      end
   endtask

   initial begin
      int            size;
      int            set_index;
      set_shape_type shape;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_value   <= '0;
      req_is_last <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single value, extremes, duplicates, already sorted and reversed runs
      send_value(42, 1'b1);
      send_value(VALUE_MAX, 1'b0);
      send_value(VALUE_MIN, 1'b0);
      send_value(0, 1'b0);
      send_value(-1, 1'b0);
      send_value(1, 1'b1);
      send_set(4, SET_CONSTANT);
      send_set(6, SET_DESCENDING);
      send_set(5, SET_ASCENDING);
      send_value(VALUE_MIN, 1'b0);
      send_value(VALUE_MAX, 1'b0);
      send_value(VALUE_MIN, 1'b0);
      send_value(VALUE_MAX, 1'b1);

      // random runs with one full store and one overflowing store
      items_sent = 0;
      set_index  = 0;
      while (items_sent < RANDOM_ITEMS || set_index <= 2) begin
         if (set_index == 1) begin
            size = DEPTH;
         end else if (set_index == 2) begin
            size = DEPTH + $urandom_range(1, 4);
         end else if ($urandom_range(0, 5) == 0) begin
            size = $urandom_range(11, 40);
         end else begin
            size = $urandom_range(1, 10);
         end
         if ($urandom_range(0, 2) != 0) begin
            shape = SET_RANDOM;
         end else begin
            shape = set_shape_type'($urandom_range(0, 3));
         end
         send_set(size, shape);
         set_index++;
      end
      start <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
